// ----- hw/rtl/gsa_pkg.sv -----
package gsa_pkg;

    // Field widths
    localparam int CAP_W     = 24;
    localparam int GEN_W     = 32;
    localparam int DEV_W     = 32;
    localparam int HSLOT_W   = 8;
    localparam int POINTS_W  = 32;
    localparam int OSLOT_W   = 4;
    localparam int LIVE_W    = 5;
    localparam int STATUS_W  = 3;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_LOST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET      = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CAP_W-1:0]    MAX_POINTS_RESET = 24'd65536;
    localparam logic [POINTS_W-1:0] BUDGET_RESET     = 32'd1048576;

    // A free slot with this generation is never handed out again
    localparam logic [GEN_W-1:0] GEN_RETIRED = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_MARK    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 3'd0,
        STATUS_DEVICE_LOST  = 3'd1,
        STATUS_BAD_CAPACITY = 3'd2,
        STATUS_NO_ROOM      = 3'd3,
        STATUS_BAD_HANDLE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_VERIFY,
        ST_FINISH
    } state_t;

    // One entry of the slot table
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [GEN_W-1:0] generation;
    } slot_entry_t;

endpackage

// ----- hw/rtl/gsa_if.sv -----
interface gsa_req_if;
    import gsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [CAP_W-1:0]     request_capacity;
    logic [DEV_W-1:0]     handle_device;
    logic [HSLOT_W-1:0]   handle_slot;
    logic [GEN_W-1:0]     handle_generation;

    modport source (
        output valid, command, request_capacity, handle_device, handle_slot,
               handle_generation,
        input  ready
    );

    modport sink (
        input  valid, command, request_capacity, handle_device, handle_slot,
               handle_generation,
        output ready
    );
endinterface

interface gsa_rsp_if;
    import gsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OSLOT_W-1:0]   out_slot;
    logic [GEN_W-1:0]     out_generation;
    logic [CAP_W-1:0]     out_capacity;
    logic [POINTS_W-1:0]  total_in_use;
    logic [LIVE_W-1:0]    live_buffers;

    modport source (
        output valid, status, out_slot, out_generation, out_capacity, total_in_use,
               live_buffers,
        input  ready
    );

    modport sink (
        input  valid, status, out_slot, out_generation, out_capacity, total_in_use,
               live_buffers,
        output ready
    );
endinterface

// ----- hw/rtl/generational_slot_allocator.sv -----
// Generational slot allocator. Commands arrive one word at a time on req and each gives one
// response word on rsp. The block works on one command at a time and raises req.ready
// only when idle. Mark-initialized passes through check and finish, release and query
// through check, verify and finish. Allocate goes from check to finish when a check fails,
// and otherwise scans the created slots, reusing the first free one or else creating a new
// slot unless the table is full: the slot table sits in one memory with a single registered
// read port, and the search for a free slot reads it one slot per cycle. A response waits
// in an output register; the next command completes once that register has been taken.
module generational_slot_allocator #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsa_pkg::CFG_W-1:0]      cfg_data,
    gsa_req_if.sink                        req,
    gsa_rsp_if.source                      rsp
);
    import gsa_pkg::*;

    localparam int            SW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int            CW         = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(SLOT_COUNT);

    // Configuration registers
    logic [DEV_W-1:0]    device_id_reg;
    logic                device_lost_reg;
    logic [CAP_W-1:0]    max_points_reg;
    logic [POINTS_W-1:0] budget_reg;

    // Control state
    state_t              state_reg, state_next;
    logic [CW-1:0]       created_reg;
    logic [POINTS_W-1:0] points_reg, points_next;
    logic [CW-1:0]       live_reg, live_next;
    logic                out_valid_reg;
    logic [CW-1:0]       scan_idx_reg;
    logic                pend_valid_reg;

    // Command and working registers
    cmd_t                cmd_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [HSLOT_W-1:0]  hslot_reg;
    logic [GEN_W-1:0]    hgen_reg;
    status_t             status_reg;
    logic [SW-1:0]       found_reg;
    logic [GEN_W-1:0]    found_gen_reg;
    logic                new_reg;
    logic [CAP_W-1:0]    qcap_reg;
    logic [SW-1:0]       pend_idx_reg;

    // Response registers
    status_t             o_status_reg;
    logic [OSLOT_W-1:0]  o_slot_reg;
    logic [GEN_W-1:0]    o_gen_reg;
    logic [CAP_W-1:0]    o_cap_reg;
    logic [POINTS_W-1:0] o_total_reg;
    logic [LIVE_W-1:0]   o_live_reg;

    // Slot memory port
    logic                ram_we;
    logic [SW-1:0]       ram_waddr;
    slot_entry_t         ram_wdata;
    logic [SW-1:0]       ram_raddr;
    slot_entry_t         rd_entry;

    logic                out_free;
    logic                commit;
    logic                slot_known;
    logic                bad_capacity;
    logic                over_budget;
    logic                rd_free;
    logic                hit;
    logic                scan_more;
    logic                handle_live;
    logic                ok_alloc;
    logic                ok_release;
    logic [POINTS_W-1:0] points_delta;
    logic [POINTS_W:0]   budget_sum;

    gsa_slot_ram #(
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    // Decode checks and table reads
    always_comb
    begin
        out_free     = !out_valid_reg || rsp.ready;
        commit       = (state_reg == ST_FINISH) && out_free;
        slot_known   = {1'b0, hslot_reg} < (HSLOT_W + 1)'(created_reg);
        bad_capacity = (cap_reg == '0) || (cap_reg > max_points_reg);
        budget_sum   = {1'b0, points_reg} + (POINTS_W + 1)'(cap_reg);
        over_budget  = budget_sum > {1'b0, budget_reg};
        rd_free      = (rd_entry.capacity == '0) && (rd_entry.generation != GEN_RETIRED);
        hit          = pend_valid_reg && rd_free;
        scan_more    = scan_idx_reg < created_reg;
        handle_live  = (dev_reg == device_id_reg) && slot_known &&
                       (rd_entry.generation == hgen_reg) && (rd_entry.capacity != '0);
        ok_alloc     = (cmd_reg == CMD_ALLOC) && (status_reg == STATUS_OK);
        ok_release   = (cmd_reg == CMD_RELEASE) && (status_reg == STATUS_OK);
    end

    // Shared accumulator for the points total and the live count
    always_comb
    begin
        points_delta = '0;
        live_next    = live_reg;
        if (ok_alloc)
        begin
            points_delta = POINTS_W'(cap_reg);
            live_next    = live_reg + CW'(1);
        end
        else if (ok_release)
        begin
            points_delta = -POINTS_W'(qcap_reg);
            live_next    = live_reg - CW'(1);
        end
        points_next = points_reg + points_delta;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (device_lost_reg || bad_capacity || over_budget)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_RELEASE, CMD_QUERY: state_next = ST_VERIFY;
                    default:                state_next = ST_FINISH;
                endcase
            end
            ST_SCAN:
            begin
                if (hit || !scan_more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_VERIFY: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake and slot memory control
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        ram_raddr = (state_reg == ST_CHECK) ? hslot_reg[SW-1:0] : scan_idx_reg[SW-1:0];
        ram_we    = commit && (ok_alloc || ok_release);
        if (cmd_reg == CMD_ALLOC)
        begin
            ram_waddr            = found_reg;
            ram_wdata.capacity   = cap_reg;
            ram_wdata.generation = found_gen_reg;
        end
        else
        begin
            ram_waddr            = hslot_reg[SW-1:0];
            ram_wdata.capacity   = '0;
            ram_wdata.generation = found_gen_reg + GEN_W'(1);
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg   <= '0;
            device_lost_reg <= 1'b0;
            max_points_reg  <= MAX_POINTS_RESET;
            budget_reg      <= BUDGET_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEVICE_ID:   device_id_reg   <= cfg_data[DEV_W-1:0];
                REG_DEVICE_LOST: device_lost_reg <= cfg_data[0];
                REG_MAX_POINTS:  max_points_reg  <= cfg_data[CAP_W-1:0];
                REG_BUDGET:      budget_reg      <= cfg_data[POINTS_W-1:0];
                default:         device_id_reg   <= device_id_reg;
            endcase
        end
    end

    // Sequencer, totals and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            created_reg    <= '0;
            points_reg     <= '0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                points_reg    <= points_next;
                live_reg      <= live_next;
                if (ok_alloc && new_reg)
                begin
                    created_reg <= created_reg + CW'(1);
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // Walk the created slots, one read per cycle
            if (state_reg == ST_CHECK)
            begin
                scan_idx_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pend_valid_reg <= scan_more;
                if (scan_more)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
            end
        end
    end

    // Command capture and per-step results
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_reg   <= cmd_t'(req.command);
                    cap_reg   <= req.request_capacity;
                    dev_reg   <= req.handle_device;
                    hslot_reg <= req.handle_slot;
                    hgen_reg  <= req.handle_generation;
                end
            end
            ST_CHECK:
            begin
                new_reg <= 1'b0;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (device_lost_reg)
                        begin
                            status_reg <= STATUS_DEVICE_LOST;
                        end
                        else if (bad_capacity)
                        begin
                            status_reg <= STATUS_BAD_CAPACITY;
                        end
                        else if (over_budget)
                        begin
                            status_reg <= STATUS_NO_ROOM;
                        end
                        else
                        begin
                            status_reg <= STATUS_OK;
                        end
                    end
                    CMD_MARK:
                    begin
                        status_reg <= slot_known ? STATUS_OK : STATUS_BAD_HANDLE;
                    end
                    default: status_reg <= STATUS_OK;
                endcase
            end
            ST_SCAN:
            begin
                pend_idx_reg <= scan_idx_reg[SW-1:0];
                if (hit)
                begin
                    found_reg     <= pend_idx_reg;
                    found_gen_reg <= rd_entry.generation;
                    new_reg       <= 1'b0;
                end
                else if (!scan_more)
                begin
                    // No reusable slot: create one unless the table is full
                    if (created_reg == FULL_COUNT)
                    begin
                        status_reg <= STATUS_NO_ROOM;
                        new_reg    <= 1'b0;
                    end
                    else
                    begin
                        found_reg     <= created_reg[SW-1:0];
                        found_gen_reg <= '0;
                        new_reg       <= 1'b1;
                    end
                end
            end
            ST_VERIFY:
            begin
                status_reg    <= handle_live ? STATUS_OK : STATUS_BAD_HANDLE;
                qcap_reg      <= rd_entry.capacity;
                found_gen_reg <= rd_entry.generation;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    o_status_reg <= status_reg;
                    o_slot_reg   <= ok_alloc ? OSLOT_W'(found_reg) : '0;
                    o_gen_reg    <= ok_alloc ? found_gen_reg : '0;
                    o_cap_reg    <= ((cmd_reg == CMD_QUERY) && (status_reg == STATUS_OK)) ?
                                    qcap_reg : '0;
                    o_total_reg  <= points_next;
                    o_live_reg   <= LIVE_W'(live_next);
                end
            end
            default: new_reg <= new_reg;
        endcase
    end

    // Drive the response channel
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = o_status_reg;
    assign rsp.out_slot       = o_slot_reg;
    assign rsp.out_generation = o_gen_reg;
    assign rsp.out_capacity   = o_cap_reg;
    assign rsp.total_in_use   = o_total_reg;
    assign rsp.live_buffers   = o_live_reg;

    a_live_within_created: assert property (
        @(posedge clk) disable iff (!rst_n)
        live_reg <= created_reg
    ) else $error("live count exceeds created slots");

    a_created_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        created_reg <= FULL_COUNT
    ) else $error("created slot count beyond table size");

    a_reuse_is_created: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && cmd_reg == CMD_ALLOC && status_reg == STATUS_OK && !new_reg)
        |-> (CW'(found_reg) < created_reg)
    ) else $error("reused slot was never created");

    a_release_no_underflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        (commit && ok_release) |-> (points_reg >= POINTS_W'(qcap_reg))
    ) else $error("release would underflow points in use");

endmodule

// ----- hw/rtl/gsa_slot_ram.sv -----
module gsa_slot_ram #(
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  gsa_pkg::slot_entry_t wdata,
    input  logic [AW-1:0]        raddr,
    output gsa_pkg::slot_entry_t rdata
);
    import gsa_pkg::*;

    slot_entry_t mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry, data registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ----- verif/generational_slot_allocator_tb.sv -----
module generational_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsa_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 600000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        cmd_t                command;
        logic [CAP_W-1:0]    request_capacity;
        logic [DEV_W-1:0]    handle_device;
        logic [HSLOT_W-1:0]  handle_slot;
        logic [GEN_W-1:0]    handle_generation;
    } req_word_t;

    typedef struct packed {
        status_t              status;
        logic [OSLOT_W-1:0]   out_slot;
        logic [GEN_W-1:0]     out_generation;
        logic [CAP_W-1:0]     out_capacity;
        logic [POINTS_W-1:0]  total_in_use;
        logic [LIVE_W-1:0]    live_buffers;
    } rsp_word_t;

    typedef struct packed {
        req_word_t  word;
        bit         typed;
        rsp_word_t  want;
    } table_row_t;

    localparam rsp_word_t FROM_MIRROR = '{STATUS_OK, 4'd0, 32'd0, 24'd0, 32'd0, 5'd0};

    // Directed words after reset (device 0, max 65536 points, budget 1M points)
    localparam int N_DIRECTED = 22;
    localparam table_row_t DIRECTED [N_DIRECTED] = '{
        '{'{CMD_QUERY, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd0, 5'd0}},
        '{'{CMD_RELEASE, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd0, 5'd0}},
        '{'{CMD_MARK, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd0, 5'd0}},
        '{'{CMD_ALLOC, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_CAPACITY, 4'd0, 32'd0, 24'd0, 32'd0, 5'd0}},
        '{'{CMD_ALLOC, 24'd65537, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_CAPACITY, 4'd0, 32'd0, 24'd0, 32'd0, 5'd0}},
        '{'{CMD_ALLOC, 24'hFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF}, 1'b1,
          '{STATUS_BAD_CAPACITY, 4'd0, 32'd0, 24'd0, 32'd0, 5'd0}},
        '{'{CMD_ALLOC, 24'd65536, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_OK, 4'd0, 32'd0, 24'd0, 32'd65536, 5'd1}},
        '{'{CMD_ALLOC, 24'd1, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_OK, 4'd1, 32'd0, 24'd0, 32'd65537, 5'd2}},
        '{'{CMD_QUERY, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_OK, 4'd0, 32'd0, 24'd65536, 32'd65537, 5'd2}},
        '{'{CMD_QUERY, 24'd0, 32'hFFFFFFFF, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd65537, 5'd2}},
        '{'{CMD_QUERY, 24'd0, 32'd0, 8'hFF, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd65537, 5'd2}},
        '{'{CMD_QUERY, 24'd0, 32'd0, 8'd1, 32'hFFFFFFFF}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd65537, 5'd2}},
        '{'{CMD_MARK, 24'd0, 32'd0, 8'd1, 32'd0}, 1'b1,
          '{STATUS_OK, 4'd0, 32'd0, 24'd0, 32'd65537, 5'd2}},
        '{'{CMD_MARK, 24'd0, 32'd0, 8'd2, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd65537, 5'd2}},
        '{'{CMD_MARK, 24'd0, 32'd0, 8'hFF, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd65537, 5'd2}},
        '{'{CMD_RELEASE, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_OK, 4'd0, 32'd0, 24'd0, 32'd1, 5'd1}},
        '{'{CMD_RELEASE, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd1, 5'd1}},
        '{'{CMD_QUERY, 24'd0, 32'd0, 8'd0, 32'd0}, 1'b1,
          '{STATUS_BAD_HANDLE, 4'd0, 32'd0, 24'd0, 32'd1, 5'd1}},
        '{'{CMD_ALLOC, 24'd100, 32'd0, 8'd0, 32'd0}, 1'b0, FROM_MIRROR},
        '{'{CMD_QUERY, 24'd0, 32'd0, 8'd0, 32'd1}, 1'b0, FROM_MIRROR},
        '{'{CMD_RELEASE, 24'd0, 32'd0, 8'd1, 32'd0}, 1'b0, FROM_MIRROR},
        '{'{CMD_ALLOC, 24'd65536, 32'd0, 8'd0, 32'd0}, 1'b0, FROM_MIRROR}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    gsa_req_if req_ch ();
    gsa_rsp_if rsp_ch ();

    generational_slot_allocator #(
        .SLOT_COUNT (SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Mirror of the register file
    logic [DEV_W-1:0]     reg_device_id   = '0;
    logic                 reg_device_lost = 1'b0;
    logic [CAP_W-1:0]     reg_max_points  = MAX_POINTS_RESET;
    logic [POINTS_W-1:0]  reg_budget      = BUDGET_RESET;

    // Mirror of the slot table
    logic [CAP_W-1:0]     mirror_capacity    [SLOTS];
    logic [GEN_W-1:0]     mirror_generation  [SLOTS];
    bit                   mirror_initialized [SLOTS];
    int                   mirror_created = 0;
    logic [POINTS_W-1:0]  mirror_points  = '0;

    rsp_word_t  pending_rsp [$];
    int         mismatches    = 0;
    int         cycle_count   = 0;
    int         send_idle_pct = 0;
    int         rcv_idle_pct  = 0;
    int         hold_left     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit handle_live(req_word_t w);
        return w.handle_device == reg_device_id && int'(w.handle_slot) < mirror_created &&
               mirror_generation[w.handle_slot] == w.handle_generation &&
               mirror_capacity[w.handle_slot] != '0;
    endfunction

    function automatic logic [LIVE_W-1:0] live_count();
        int i;
        int n;
        n = 0;
        for (i = 0; i < mirror_created; i++)
            if (mirror_capacity[i] != '0)
                n++;
        return LIVE_W'(n);
    endfunction

    // Apply one command to the mirror and return the word the block should answer
    function automatic rsp_word_t table_response(req_word_t w);
        rsp_word_t            r;
        logic [POINTS_W-1:0]  room;
        int                   found;
        int                   i;
        r = FROM_MIRROR;
        case (w.command)
            CMD_ALLOC:
            begin
                room = (mirror_points < reg_budget) ? reg_budget - mirror_points : '0;
                if (reg_device_lost)
                    r.status = STATUS_DEVICE_LOST;
                else if (w.request_capacity == '0 || w.request_capacity > reg_max_points)
                    r.status = STATUS_BAD_CAPACITY;
                else if (POINTS_W'(w.request_capacity) > room)
                    r.status = STATUS_NO_ROOM;
                else
                begin
                    // first free slot that is not retired, else a fresh one
                    found = -1;
                    for (i = 0; i < mirror_created; i++)
                        if (found < 0 && mirror_capacity[i] == '0 &&
                            mirror_generation[i] != GEN_RETIRED)
                            found = i;
                    if (found < 0)
                    begin
                        if (mirror_created >= SLOTS)
                            r.status = STATUS_NO_ROOM;
                        else
                        begin
                            found = mirror_created;
                            mirror_generation[found]  = '0;
                            mirror_capacity[found]    = '0;
                            mirror_initialized[found] = 1'b0;
                            mirror_created++;
                        end
                    end
                    if (r.status == STATUS_OK)
                    begin
                        mirror_capacity[found]    = w.request_capacity;
                        mirror_initialized[found] = 1'b0;
                        mirror_points             = mirror_points + w.request_capacity;
                        r.out_slot                = OSLOT_W'(found);
                        r.out_generation          = mirror_generation[found];
                    end
                end
            end
            CMD_RELEASE:
            begin
                if (handle_live(w))
                begin
                    mirror_points = mirror_points - mirror_capacity[w.handle_slot];
                    mirror_capacity[w.handle_slot]    = '0;
                    mirror_initialized[w.handle_slot] = 1'b0;
                    mirror_generation[w.handle_slot]  = mirror_generation[w.handle_slot] + 1;
                end
                else
                    r.status = STATUS_BAD_HANDLE;
            end
            CMD_QUERY:
            begin
                if (handle_live(w))
                    r.out_capacity = mirror_capacity[w.handle_slot];
                else
                    r.status = STATUS_BAD_HANDLE;
            end
            default:
            begin
                if (int'(w.handle_slot) < mirror_created)
                    mirror_initialized[w.handle_slot] = 1'b1;
                else
                    r.status = STATUS_BAD_HANDLE;
            end
        endcase
        r.total_in_use = mirror_points;
        r.live_buffers = live_count();
        return r;
    endfunction

    // Mostly well-formed handles taken from the mirror, the rest noise
    function automatic req_word_t random_word();
        req_word_t  w;
        int         pick;
        int         s;
        int         n;
        w.command           = CMD_ALLOC;
        w.request_capacity  = CAP_W'($urandom);
        w.handle_device     = $urandom;
        w.handle_slot       = HSLOT_W'($urandom);
        w.handle_generation = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 38)
        begin
            // allocate: mostly a legal size, some zero or oversized
            n = $urandom_range(0, 19);
            if (n == 0)
                w.request_capacity = '0;
            else if (n == 1 && reg_max_points != '1)
                w.request_capacity = CAP_W'($urandom_range(reg_max_points + 1, 24'hFFFFFF));
            else if (n > 2)
                w.request_capacity = CAP_W'($urandom_range(1, reg_max_points));
        end
        else if (pick < 88)
        begin
            w.command = (pick < 63) ? CMD_RELEASE : CMD_QUERY;
            if (mirror_created != 0 && $urandom_range(0, 4) != 0)
            begin
                s = $urandom_range(0, mirror_created - 1);
                for (n = 0; n < 4 && mirror_capacity[s] == '0; n++)
                    s = $urandom_range(0, mirror_created - 1);
                w.handle_device     = reg_device_id;
                w.handle_slot       = HSLOT_W'(s);
                w.handle_generation = mirror_generation[s];
                // corrupt a few: stale generation or foreign device
                n = $urandom_range(0, 9);
                if (n == 0)
                    w.handle_generation = mirror_generation[s] - 1;
                else if (n == 1)
                    w.handle_device = ~reg_device_id;
            end
        end
        else
        begin
            w.command = CMD_MARK;
            if (mirror_created != 0 && $urandom_range(0, 4) != 0)
                w.handle_slot = HSLOT_W'($urandom_range(0, mirror_created - 1));
        end
        return w;
    endfunction

    // Offer one word; called and returns at a falling edge
    task automatic offer(input req_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t predicted;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.command           = w.command;
        req_ch.request_capacity  = w.request_capacity;
        req_ch.handle_device     = w.handle_device;
        req_ch.handle_slot       = w.handle_slot;
        req_ch.handle_generation = w.handle_generation;
        req_ch.valid             = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = table_response(w);
        pending_rsp.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Hold the sender until every response is back and the block has settled
    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_DEVICE_ID:   reg_device_id   = value;
            REG_DEVICE_LOST: reg_device_lost = value[0];
            REG_MAX_POINTS:  reg_max_points  = value[CAP_W-1:0];
            default:         reg_budget      = value;
        endcase
    endtask

    task automatic run_phase(input int count, input int send_pct, input int rcv_pct);
        int k;
        send_idle_pct = send_pct;
        rcv_idle_pct  = rcv_pct;
        for (k = 0; k < count; k++)
            offer(random_word(), 1'b0, FROM_MIRROR);
    endtask

    // Receiver: random backpressure, or a long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left    = hold_left - 1;
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Compare each response word with the oldest expectation
    always @(posedge clk)
    begin : rsp_monitor
        rsp_word_t got;
        rsp_word_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{status_t'(rsp_ch.status), rsp_ch.out_slot, rsp_ch.out_generation,
                    rsp_ch.out_capacity, rsp_ch.total_in_use, rsp_ch.live_buffers};
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: response word with none expected, status %0d",
                             $realtime, got.status);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.status !== want.status || got.out_slot !== want.out_slot ||
                    got.out_generation !== want.out_generation ||
                    got.out_capacity !== want.out_capacity ||
                    got.total_in_use !== want.total_in_use ||
                    got.live_buffers !== want.live_buffers)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t: mismatch exp/got status %0d/%0d slot %0d/%0d ",
                                  "gen %h/%h cap %h/%h total %h/%h live %0d/%0d"},
                                 $realtime, want.status, got.status,
                                 want.out_slot, got.out_slot,
                                 want.out_generation, got.out_generation,
                                 want.out_capacity, got.out_capacity,
                                 want.total_in_use, got.total_in_use,
                                 want.live_buffers, got.live_buffers);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n                    = 1'b0;
        cfg_write                = 1'b0;
        cfg_index                = REG_DEVICE_ID;
        cfg_data                 = '0;
        req_ch.valid             = 1'b0;
        req_ch.command           = CMD_ALLOC;
        req_ch.request_capacity  = '0;
        req_ch.handle_device     = '0;
        req_ch.handle_slot       = '0;
        req_ch.handle_generation = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed words from the reset state
        send_idle_pct = 37;
        rcv_idle_pct  = 67;
        for (i = 0; i < N_DIRECTED; i++)
            offer(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);

        // Tight budget, small buffers: budget and table limits both hit
        wait_idle();
        write_reg(REG_DEVICE_ID, $urandom);
        write_reg(REG_MAX_POINTS, 32'd4096);
        write_reg(REG_BUDGET, 32'd30000);
        run_phase(300, 37, 67);

        // Widest registers: only the table size limits
        wait_idle();
        write_reg(REG_DEVICE_ID, 32'hFFFFFFFF);
        write_reg(REG_MAX_POINTS, 32'h00FFFFFF);
        write_reg(REG_BUDGET, 32'hFFFFFFFF);
        run_phase(300, 37, 67);

        // Device lost: allocation refused, handles still work
        wait_idle();
        write_reg(REG_DEVICE_LOST, 32'd1);
        run_phase(80, 67, 37);

        // Smallest limits
        wait_idle();
        write_reg(REG_DEVICE_LOST, 32'd0);
        write_reg(REG_DEVICE_ID, 32'd0);
        write_reg(REG_MAX_POINTS, 32'd1);
        write_reg(REG_BUDGET, 32'd1);
        run_phase(150, 67, 37);

        // Back to the reset limits on a new device
        wait_idle();
        write_reg(REG_DEVICE_ID, $urandom);
        write_reg(REG_MAX_POINTS, 32'(MAX_POINTS_RESET));
        write_reg(REG_BUDGET, BUDGET_RESET);
        run_phase(300, 67, 37);

        // Budget dropped below what is in use
        wait_idle();
        write_reg(REG_BUDGET, 32'd1);
        run_phase(100, 0, 0);

        // Random limits, receiver stalled long enough to back up the block
        wait_idle();
        write_reg(REG_DEVICE_ID, $urandom);
        write_reg(REG_MAX_POINTS, $urandom_range(256, 24'hFFFFFF));
        write_reg(REG_BUDGET, $urandom_range(32'h00100000, 32'hFFFFFFFF));
        hold_left = HOLD_CYCLES;
        run_phase(500, 0, 0);

        wait_idle();
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_if.sv
hw/rtl/gsa_slot_ram.sv
hw/rtl/generational_slot_allocator.sv
verif/generational_slot_allocator_tb.sv
